>>> rtl/matrix_factorization_sgd_step_macros.svh
// Assertion macros shared by the matrix factorization SGD step RTL.
`ifndef MATRIX_FACTORIZATION_SGD_STEP_MACROS_SVH
`define MATRIX_FACTORIZATION_SGD_STEP_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off while in reset.
`define MFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off while in reset.
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mfs_pkg.sv
// Types, codes and saturation helper for the matrix factorization SGD step.
package mfs_pkg;

    typedef logic signed [31:0] t_q;

    localparam logic [2:0] MODE_TRAIN   = 3'd0;
    localparam logic [2:0] MODE_PREDICT = 3'd1;
    localparam logic [2:0] MODE_LOAD_UB = 3'd2;
    localparam logic [2:0] MODE_LOAD_IB = 3'd3;
    localparam logic [2:0] MODE_LOAD_UF = 3'd4;
    localparam logic [2:0] MODE_LOAD_IF = 3'd5;

    localparam logic [2:0] CFG_GLOBAL_MEAN  = 3'd0;
    localparam logic [2:0] CFG_BIAS_RATE    = 3'd1;
    localparam logic [2:0] CFG_FACTOR_RATE  = 3'd2;
    localparam logic [2:0] CFG_BIAS_DECAY   = 3'd3;
    localparam logic [2:0] CFG_FACTOR_DECAY = 3'd4;

    localparam logic [26:0] PRED_MIN = 27'd16777216;
    localparam logic [26:0] PRED_MAX = 27'd83886080;

    localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
    localparam logic signed [47:0] SAT_LO = -48'sd2147483648;

    typedef struct packed {
        logic [2:0]         mode;
        logic [9:0]         user_id;
        logic [10:0]        item_id;
        logic [2:0]         rating;
        logic               user_has_several;
        logic [3:0]         factor_index;
        logic signed [31:0] load_value;
    } t_mfs_in;

    typedef struct packed {
        logic [26:0]        prediction;
        logic signed [27:0] error;
    } t_mfs_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DOT,
        S_DDRAIN,
        S_SUM,
        S_CLAMP,
        S_UPD,
        S_UDRAIN,
        S_DONE
    } t_state;

    function automatic t_q sat32(input logic signed [47:0] x);
        t_q res;
        if (x > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/mfs_ram.sv
// Single-port-write, single-port-read synchronous table memory with registered read data.
module mfs_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  mfs_pkg::t_q   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output mfs_pkg::t_q   o_rdata
);
    import mfs_pkg::*;

    t_q r_mem [DEPTH];
    t_q r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mfs_qmul.sv
// Registered Q8.24 multiplier: exact 64-bit product, floor shift by 24.
module mfs_qmul (
    input  logic               i_clk,
    input  mfs_pkg::t_q        i_a,
    input  mfs_pkg::t_q        i_b,
    output logic signed [39:0] o_p
);
    import mfs_pkg::*;

    logic signed [63:0] prod;
    logic signed [39:0] r_p;

    assign prod = i_a * i_b;

    // dropping the low bits of a two's complement value rounds toward minus infinity
    always_ff @(posedge i_clk) begin
        r_p <= prod[63:24];
    end

    assign o_p = r_p;

endmodule

>>> rtl/matrix_factorization_sgd_step.sv
// Matrix factorization SGD step: bias and factor tables in block memories, one item at a time.
// Every accepted item ends in a result strobe, in train, predict and load modes and an unused mode;
// the next start is taken the cycle after the strobe.
// One factor pair is read per cycle from each factor memory, in a dot pass then an update pass.
// Synchronous active-low reset clears control and configuration; tables hold no reset value.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
`include "matrix_factorization_sgd_step_macros.svh"
module matrix_factorization_sgd_step #(
    parameter int USERS   = 1024,
    parameter int ITEMS   = 2048,
    parameter int FACTORS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mfs_pkg::t_mfs_in  i_item,
    output logic              o_valid,
    output mfs_pkg::t_mfs_out o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import mfs_pkg::*;

    localparam int UAW   = $clog2(USERS);
    localparam int IAW   = $clog2(ITEMS);
    localparam int FUAW  = $clog2(USERS * FACTORS);
    localparam int FIAW  = $clog2(ITEMS * FACTORS);
    localparam int KW    = $clog2(FACTORS + 1);
    localparam int ACC_W = 41 + $clog2(FACTORS);
    localparam int SUM_W = ACC_W + 2;

    t_state r_state, n_state;

    t_q          r_gmean;
    logic [30:0] r_brate, r_frate, r_bdecay, r_fdecay;

    t_mfs_in          r_item;
    logic             r_uok, r_iok, r_fok;
    logic [FUAW-1:0]  r_ubase, r_ua;
    logic [FIAW-1:0]  r_ibase, r_ia;
    logic [FUAW-1:0]  n_ubase;
    logic [FIAW-1:0]  n_ibase;
    logic [KW-1:0]    r_k;
    logic [1:0]       r_drain;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SUM_W-1:0] r_sum;
    logic [26:0]        r_pred;
    logic signed [27:0] r_err;

    // update / dot pipeline
    logic            r0_v, r0_dot, r0_bias;
    logic [FUAW-1:0] r0_ua;
    logic [FIAW-1:0] r0_ia;
    logic            r1_v, r1_dot, r1_bias;
    t_q              r1_p, r1_q;
    logic [FUAW-1:0] r1_ua;
    logic [FIAW-1:0] r1_ia;
    logic            r2_v, r2_bias;
    t_q              r2_p, r2_q;
    logic [FUAW-1:0] r2_ua;
    logic [FIAW-1:0] r2_ia;

    logic issue, dot_ph, accept;

    t_q ub_rd, ib_rd, uf_rd, if_rd;
    t_q ub_v, ib_v, uf_v, if_v;
    t_q s1_p, s1_q, e32, dec, rate, eq_a, tp, tq, np, nq;
    logic signed [39:0] eq_out, dp_out, ep_out, dq_out, rp_out, rq_out, xp, xq;

    logic [26:0]        clamp_pred;
    logic signed [27:0] clamp_err;

    logic            ub_we, ib_we, uf_we, if_we;
    t_q              ub_wd, ib_wd, uf_wd, if_wd;
    logic [FUAW-1:0] uf_wa;
    logic [FIAW-1:0] if_wa;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.mode)
                        MODE_TRAIN, MODE_PREDICT: n_state = S_DOT;
                        MODE_LOAD_UB, MODE_LOAD_IB,
                        MODE_LOAD_UF, MODE_LOAD_IF: n_state = S_LOAD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: n_state = S_DONE;
            S_DOT: begin
                if (r_k == KW'(FACTORS - 1)) n_state = S_DDRAIN;
            end
            S_DDRAIN: begin
                if (r_drain == 2'd1) n_state = S_SUM;
            end
            S_SUM: n_state = S_CLAMP;
            S_CLAMP: begin
                if (r_item.mode == MODE_TRAIN) n_state = S_UPD;
                else n_state = S_DONE;
            end
            S_UPD: begin
                if (r_k == KW'(FACTORS)) n_state = S_UDRAIN;
            end
            S_UDRAIN: begin
                if (r_drain == 2'd2) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy     = (r_state != S_IDLE);
        o_valid  = (r_state == S_DONE);
        issue    = (r_state == S_DOT) || (r_state == S_UPD);
        dot_ph   = (r_state == S_DOT);
        accept   = start && (r_state == S_IDLE);
    end

    assign o_result.prediction = r_pred;
    assign o_result.error      = r_err;

    assign n_ubase = FUAW'(i_item.user_id) * FUAW'(FACTORS);
    assign n_ibase = FIAW'(i_item.item_id) * FIAW'(FACTORS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_drain  <= '0;
            r_gmean  <= '0;
            r_brate  <= '0;
            r_frate  <= '0;
            r_bdecay <= '0;
            r_fdecay <= '0;
            r0_v     <= 1'b0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_k     <= '0;
                r_drain <= '0;
            end else begin
                r_k     <= r_k + 1'b1;
                r_drain <= r_drain + 2'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GLOBAL_MEAN:  r_gmean  <= i_cfg_data;
                    CFG_BIAS_RATE:    r_brate  <= i_cfg_data[30:0];
                    CFG_FACTOR_RATE:  r_frate  <= i_cfg_data[30:0];
                    CFG_BIAS_DECAY:   r_bdecay <= i_cfg_data[30:0];
                    CFG_FACTOR_DECAY: r_fdecay <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            r0_v <= issue;
            r1_v <= r0_v;
            r2_v <= r1_v && !r1_dot;
        end
    end

    // ---------------- item registers and address walk ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_item;
            r_uok   <= int'(i_item.user_id) < USERS;
            r_iok   <= int'(i_item.item_id) < ITEMS;
            r_fok   <= int'(i_item.factor_index) < FACTORS;
            r_ubase <= n_ubase;
            r_ibase <= n_ibase;
            r_ua    <= n_ubase;
            r_ia    <= n_ibase;
            r_acc   <= '0;
            r_pred  <= '0;
            r_err   <= '0;
        end else begin
            case (r_state)
                S_DOT: begin
                    r_ua <= r_ua + 1'b1;
                    r_ia <= r_ia + 1'b1;
                end
                S_CLAMP: begin
                    r_ua   <= r_ubase;
                    r_ia   <= r_ibase;
                    r_pred <= clamp_pred;
                    r_err  <= clamp_err;
                end
                S_UPD: begin
                    // first update slot is the bias pair, factors follow
                    if (r_k != '0) begin
                        r_ua <= r_ua + 1'b1;
                        r_ia <= r_ia + 1'b1;
                    end
                end
                S_SUM: begin
                    r_sum <= SUM_W'(r_gmean) + SUM_W'(ub_v) + SUM_W'(ib_v)
                           + (r_item.user_has_several ? SUM_W'(r_acc) : '0);
                end
                default: ;
            endcase
            if (r1_v && r1_dot) begin
                r_acc <= r_acc + ACC_W'(eq_out);
            end
        end
    end

    // clamp to 1.0..5.0 and form the error, which is zero outside training
    always_comb begin
        if (r_sum <= $signed(SUM_W'(PRED_MIN))) begin
            clamp_pred = PRED_MIN;
        end else if (r_sum >= $signed(SUM_W'(PRED_MAX))) begin
            clamp_pred = PRED_MAX;
        end else begin
            clamp_pred = r_sum[26:0];
        end
        if (r_item.mode == MODE_TRAIN) begin
            clamp_err = $signed({1'b0, r_item.rating, 24'd0}) - $signed({1'b0, clamp_pred});
        end else begin
            clamp_err = '0;
        end
    end

    // ---------------- pipeline ----------------
    always_comb begin
        ub_v = r_uok ? ub_rd : '0;
        ib_v = r_iok ? ib_rd : '0;
        uf_v = r_uok ? uf_rd : '0;
        if_v = r_iok ? if_rd : '0;
        e32  = 32'(r_err);
        s1_p = r0_bias ? ub_v : uf_v;
        s1_q = r0_bias ? ib_v : if_v;
        dec  = {1'b0, (r0_bias ? r_bdecay : r_fdecay)};
        eq_a = r0_dot ? s1_p : e32;
        xp   = r1_bias ? 40'(e32) : eq_out;
        xq   = r1_bias ? 40'(e32) : ep_out;
        tp   = sat32(48'(xp) - 48'(dp_out));
        tq   = sat32(48'(xq) - 48'(dq_out));
        rate = {1'b0, (r1_bias ? r_brate : r_frate)};
        np   = sat32(48'(r2_p) + 48'(rp_out));
        nq   = sat32(48'(r2_q) + 48'(rq_out));
    end

    always_ff @(posedge i_clk) begin
        r0_dot  <= dot_ph;
        r0_bias <= (r_state == S_UPD) && (r_k == '0);
        r0_ua   <= r_ua;
        r0_ia   <= r_ia;
        r1_dot  <= r0_dot;
        r1_bias <= r0_bias;
        r1_p    <= s1_p;
        r1_q    <= s1_q;
        r1_ua   <= r0_ua;
        r1_ia   <= r0_ia;
        r2_bias <= r1_bias;
        r2_p    <= r1_p;
        r2_q    <= r1_q;
        r2_ua   <= r1_ua;
        r2_ia   <= r1_ia;
    end

    mfs_qmul u_mul_eq (.i_clk(i_clk), .i_a(eq_a), .i_b(s1_q), .o_p(eq_out));
    mfs_qmul u_mul_dp (.i_clk(i_clk), .i_a(dec),  .i_b(s1_p), .o_p(dp_out));
    mfs_qmul u_mul_ep (.i_clk(i_clk), .i_a(e32),  .i_b(s1_p), .o_p(ep_out));
    mfs_qmul u_mul_dq (.i_clk(i_clk), .i_a(dec),  .i_b(s1_q), .o_p(dq_out));
    mfs_qmul u_mul_rp (.i_clk(i_clk), .i_a(rate), .i_b(tp),   .o_p(rp_out));
    mfs_qmul u_mul_rq (.i_clk(i_clk), .i_a(rate), .i_b(tq),   .o_p(rq_out));

    // ---------------- memory writes ----------------
    always_comb begin
        if (r_state == S_LOAD) begin
            ub_we = (r_item.mode == MODE_LOAD_UB) && r_uok;
            ib_we = (r_item.mode == MODE_LOAD_IB) && r_iok;
            uf_we = (r_item.mode == MODE_LOAD_UF) && r_uok && r_fok;
            if_we = (r_item.mode == MODE_LOAD_IF) && r_iok && r_fok;
            ub_wd = r_item.load_value;
            ib_wd = r_item.load_value;
            uf_wd = r_item.load_value;
            if_wd = r_item.load_value;
            uf_wa = r_ubase + FUAW'(r_item.factor_index);
            if_wa = r_ibase + FIAW'(r_item.factor_index);
        end else begin
            ub_we = r2_v && r2_bias && r_uok;
            ib_we = r2_v && r2_bias && r_iok;
            uf_we = r2_v && !r2_bias && r_uok;
            if_we = r2_v && !r2_bias && r_iok;
            ub_wd = np;
            ib_wd = nq;
            uf_wd = np;
            if_wd = nq;
            uf_wa = r2_ua;
            if_wa = r2_ia;
        end
    end

    mfs_ram #(.DEPTH(USERS)) u_ub (
        .i_clk(i_clk), .i_we(ub_we), .i_waddr(UAW'(r_item.user_id)), .i_wdata(ub_wd),
        .i_raddr(UAW'(r_item.user_id)), .o_rdata(ub_rd)
    );
    mfs_ram #(.DEPTH(ITEMS)) u_ib (
        .i_clk(i_clk), .i_we(ib_we), .i_waddr(IAW'(r_item.item_id)), .i_wdata(ib_wd),
        .i_raddr(IAW'(r_item.item_id)), .o_rdata(ib_rd)
    );
    mfs_ram #(.DEPTH(USERS * FACTORS)) u_uf (
        .i_clk(i_clk), .i_we(uf_we), .i_waddr(uf_wa), .i_wdata(uf_wd),
        .i_raddr(r_ua), .o_rdata(uf_rd)
    );
    mfs_ram #(.DEPTH(ITEMS * FACTORS)) u_if (
        .i_clk(i_clk), .i_we(if_we), .i_waddr(if_wa), .i_wdata(if_wd),
        .i_raddr(r_ia), .o_rdata(if_rd)
    );

    // ---------------- assertions ----------------
    `MFS_ASSERT_NEXT(a_done_to_idle, o_valid, !busy, "result strobe not followed by idle")
    `MFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `MFS_ASSERT_NOW(a_idle_no_write, r_state == S_IDLE, !(uf_we || if_we || ub_we || ib_we), "table write while idle")
    `MFS_ASSERT_NOW(a_wb_in_update, r2_v, r_state == S_UPD || r_state == S_UDRAIN, "write-back outside update pass")

endmodule
